[design/vtr_pkg.sv]
// Package for the virtual trackball rotation block.
// Holds the fixed-point constants, pipeline latencies, shared types and the arctangent table.
// No dependencies.
package vtr_pkg;

  localparam int FracBits    = 14;
  localparam int AngBits     = 30;
  localparam int CordicSteps = 30;
  localparam int PreBits     = 20;
  localparam int AngShift    = AngBits - FracBits;

  localparam int SqrtLat   = 32;
  localparam int DivLat    = 16;
  localparam int CordicLat = CordicSteps;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  localparam logic [1:0]  RegRadius   = 2'd0;
  localparam logic [14:0] RadiusReset = 15'((4 << FracBits) / 5);

  localparam logic [33:0] PiQ30  = 34'd3373259426;
  localparam logic [15:0] PiFrac = 16'((PiQ30 + (34'd1 << (AngShift - 1))) >> AngShift);

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic        sph0;
    logic        sph1;
    logic [31:0] arg0;
    logic [31:0] arg1;
  } fe_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [30:0] atan_entry(input int i);
    logic [30:0] v;
    case (i)
      0:       v = 31'd843314856;
      1:       v = 31'd497837829;
      2:       v = 31'd263043836;
      3:       v = 31'd133525158;
      4:       v = 31'd67021686;
      5:       v = 31'd33543515;
      6:       v = 31'd16775850;
      7:       v = 31'd8388437;
      8:       v = 31'd4194282;
      9:       v = 31'd2097149;
      default: v = 31'((64'd1 << (AngBits - i)) - 64'd1);
    endcase
    return v;
  endfunction

endpackage

[design/virtual_trackball_rotation.sv]
// Top level of the virtual trackball rotation block: radius register, front end,
// queue and back end. Depends on vtr_pkg, vtr_front, vtr_fifo and vtr_back.
//
//   Port group  Direction  Contents
//   s_axis      in         start and end points of a drag
//   m_axis      out        unit rotation axis, angle and degenerate flag
//   APB         in/out     ball radius register at address 0
//
// One point pair is taken and one result given per cycle when the output is taken.
// From the accepting edge a pair passes the front register, the queue, and 116 back
// stages set by the lift square root and divider, five product and sum stages, the
// angle square root, the 30-step CORDIC and the output register.
// Reset sets the radius to 0.8 and empties the queue and pipeline; no clearing pass.
// A stalled output holds the whole back end; the queue then fills and stops input.
module virtual_trackball_rotation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // axis_x, axis_y, axis_z, angle
  output logic [0:0]  m_axis_tuser,   // degenerate
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vtr_pkg::*;

  logic [14:0] radius_q;
  logic [29:0] r2_q;
  fe_t         wr_entry, head;
  fifo_stat_t  stat;
  logic        push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (psel && penable && pwrite && pready && paddr == RegRadius) begin
      radius_q <= pwdata[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= 30'(radius_q) * 30'(radius_q);
  end

  assign pready = 1'b1;
  assign prdata = (paddr == RegRadius) ? 32'(radius_q) : '0;

  vtr_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .r2_i   (r2_q),
    .stat_i (stat),
    .push_o (push),
    .entry_o(wr_entry)
  );

  vtr_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .wdata_i(wr_entry),
    .pop_i  (pop),
    .rdata_o(head),
    .stat_o (stat)
  );

  vtr_back u_back (
    .clk_i,
    .rst_ni,
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .r2_i   (r2_q),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[47:0] == '0)
    else $error("degenerate result with non-zero axis");

  a_angle_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:48] <= PiFrac)
    else $error("angle above pi");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == RegRadius |=> radius_q == $past(pwdata[14:0]))
    else $error("radius write lost");

endmodule

[design/vtr_isqrt.sv]
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Depends on vtr_pkg for the latency.
module vtr_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import vtr_pkg::*;

  logic [63:0] rem_q [SqrtLat];
  logic [31:0] res_q [SqrtLat];

  for (genvar k = 0; k < SqrtLat; k++) begin : g_stage
    localparam int B = SqrtLat - 1 - k;
    logic [63:0] rem_in;
    logic [31:0] res_in;
    logic [65:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = (66'(res_in) << (B + 1)) + (66'd1 << (2 * B));
    assign ge    = 66'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 64'(66'(rem_in) - trial) : rem_in;
        res_q[k] <= ge ? (res_in | (32'd1 << B)) : res_in;
      end
    end
  end

  assign root_o = res_q[SqrtLat-1];

endmodule

[design/vtr_div.sv]
// Pipelined restoring divider, 48-bit dividend by 32-bit divisor, 16-bit quotient.
// Depends on vtr_pkg for the latency.
module vtr_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [47:0] num_i,
  input  logic [31:0] den_i,
  output logic [15:0] quo_o
);
  import vtr_pkg::*;

  logic [47:0] rem_q [DivLat];
  logic [31:0] den_q [DivLat];
  logic [15:0] quo_q [DivLat];

  for (genvar k = 0; k < DivLat; k++) begin : g_stage
    localparam int B = DivLat - 1 - k;
    logic [47:0] rem_in;
    logic [31:0] den_in;
    logic [15:0] quo_in;
    logic [47:0] sub;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign sub = 48'(den_in) << B;
    assign ge  = rem_in >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_in - sub : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= ge ? (quo_in | (16'd1 << B)) : quo_in;
      end
    end
  end

  assign quo_o = quo_q[DivLat-1];

endmodule

[design/vtr_cordic.sv]
// Pipelined CORDIC in vectoring mode, giving atan2(y, x) in Q30 radians.
// Depends on vtr_pkg for the step count and the arctangent table.
module vtr_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [48:0] x_i,
  input  logic signed [48:0] y_i,
  output logic signed [32:0] z_o
);
  import vtr_pkg::*;

  logic signed [48:0] x_q [CordicLat];
  logic signed [48:0] y_q [CordicLat];
  logic signed [32:0] z_q [CordicLat];

  for (genvar k = 0; k < CordicLat; k++) begin : g_stage
    localparam logic signed [32:0] Ang = 33'(atan_entry(k));
    logic signed [48:0] x_in;
    logic signed [48:0] y_in;
    logic signed [32:0] z_in;
    logic signed [48:0] xs;
    logic signed [48:0] ys;

    if (k == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[48]) begin
          x_q[k] <= x_in + ys;
          y_q[k] <= y_in - xs;
          z_q[k] <= z_in + Ang;
        end else begin
          x_q[k] <= x_in - ys;
          y_q[k] <= y_in + xs;
          z_q[k] <= z_in - Ang;
        end
      end
    end
  end

  assign z_o = z_q[CordicLat-1];

endmodule

[design/vtr_front.sv]
// Front end: takes in point pairs, squares the coordinates and decides sphere or hyperbola.
// Depends on vtr_pkg for the queue entry and status types.
module vtr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,
  input  logic [29:0]         r2_i,
  input  vtr_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output vtr_pkg::fe_t        entry_o
);
  import vtr_pkg::*;

  logic               f1_valid_q;
  logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
  logic [31:0]        sx0_q, sy0_q, sx1_q, sy1_q;
  logic [31:0]        d2_0, d2_1;
  logic               sph0, sph1;

  assign s_axis_tready = ~f1_valid_q | ~stat_i.full;
  assign push_o        = f1_valid_q & ~stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      f1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      x0_q  <= s_axis_tdata[15:0];
      y0_q  <= s_axis_tdata[31:16];
      x1_q  <= s_axis_tdata[47:32];
      y1_q  <= s_axis_tdata[63:48];
      sx0_q <= 32'($signed(s_axis_tdata[15:0])) * 32'($signed(s_axis_tdata[15:0]));
      sy0_q <= 32'($signed(s_axis_tdata[31:16])) * 32'($signed(s_axis_tdata[31:16]));
      sx1_q <= 32'($signed(s_axis_tdata[47:32])) * 32'($signed(s_axis_tdata[47:32]));
      sy1_q <= 32'($signed(s_axis_tdata[63:48])) * 32'($signed(s_axis_tdata[63:48]));
    end
  end

  always_comb begin
    d2_0 = sx0_q + sy0_q;
    d2_1 = sx1_q + sy1_q;
    sph0 = {d2_0, 1'b0} < 33'(r2_i);
    sph1 = {d2_1, 1'b0} < 33'(r2_i);
    entry_o.x0   = x0_q;
    entry_o.y0   = y0_q;
    entry_o.x1   = x1_q;
    entry_o.y1   = y1_q;
    entry_o.sph0 = sph0;
    entry_o.sph1 = sph1;
    entry_o.arg0 = sph0 ? 32'(r2_i) - d2_0 : d2_0;
    entry_o.arg1 = sph1 ? 32'(r2_i) - d2_1 : d2_1;
  end

endmodule

[design/vtr_fifo.sv]
// Short queue between the front end and the arithmetic back end.
// Depends on vtr_pkg for the entry type and depth.
module vtr_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vtr_pkg::fe_t        wdata_i,
  input  logic                pop_i,
  output vtr_pkg::fe_t        rdata_o,
  output vtr_pkg::fifo_stat_t stat_o
);
  import vtr_pkg::*;

  fe_t                 mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   cnt_q;

  assign stat_o.full  = cnt_q == (FifoPtrW + 1)'(FifoDepth);
  assign stat_o.empty = cnt_q == '0;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[design/vtr_back.sv]
// Back end: lifts the points, forms and normalises the cross product and finds the angle.
// Depends on vtr_pkg, vtr_isqrt, vtr_div and vtr_cordic.
module vtr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vtr_pkg::fe_t        head_i,
  input  vtr_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  input  logic [29:0]         r2_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,
  output logic [0:0]          m_axis_tuser
);
  import vtr_pkg::*;

  localparam int LvlLift  = SqrtLat + DivLat;
  localparam int LvlArg   = LvlLift + 5;
  localparam int LvlSum   = LvlLift + 6;
  localparam int LvlOut   = LvlArg + SqrtLat + CordicLat;
  localparam int AxisPad  = LvlOut - (LvlSum + SqrtLat + DivLat);
  localparam int SidePad  = LvlOut - LvlSum;
  localparam int FlagPad  = LvlOut - LvlArg;

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic        sph0;
    logic        sph1;
  } side_t;

  logic adv;
  logic vld_q [LvlOut];
  logic out_valid_q;
  logic [63:0] out_data_q;
  logic        out_deg_q;

  assign adv   = ~out_valid_q | m_axis_tready;
  assign pop_o = adv & ~stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LvlOut; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= pop_o;
      for (int i = 1; i < LvlOut; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[LvlOut-1];
    end
  end

  // Lift: one root per point, then the hyperbola divide.
  side_t       sa_q [LvlLift];
  side_t       sa_in;
  logic [31:0] root0, root1;
  logic [31:0] rt_q [DivLat];
  logic [15:0] quo0, quo1;

  assign sa_in = '{x0: head_i.x0, y0: head_i.y0, x1: head_i.x1, y1: head_i.y1,
                   sph0: head_i.sph0, sph1: head_i.sph1};

  vtr_isqrt u_sqrt0 (.clk_i, .en_i(adv), .rad_i(64'(head_i.arg0)), .root_o(root0));
  vtr_isqrt u_sqrt1 (.clk_i, .en_i(adv), .rad_i(64'(head_i.arg1)), .root_o(root1));

  vtr_div u_div0 (.clk_i, .en_i(adv), .num_i(48'(r2_i) + 48'(root0[15:0])),
                  .den_i({15'd0, root0[15:0], 1'b0}), .quo_o(quo0));
  vtr_div u_div1 (.clk_i, .en_i(adv), .num_i(48'(r2_i) + 48'(root1[15:0])),
                  .den_i({15'd0, root1[15:0], 1'b0}), .quo_o(quo1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q[0] <= sa_in;
      for (int i = 1; i < LvlLift; i++) begin
        sa_q[i] <= sa_q[i-1];
      end
      rt_q[0] <= {root1[15:0], root0[15:0]};
      for (int i = 1; i < DivLat; i++) begin
        rt_q[i] <= rt_q[i-1];
      end
    end
  end

  side_t       sa;
  logic [15:0] rt0, rt1, z0_d, z1_d;

  always_comb begin
    sa   = sa_q[LvlLift-1];
    rt0  = rt_q[DivLat-1][15:0];
    rt1  = rt_q[DivLat-1][31:16];
    z0_d = sa.sph0 ? rt0 : ((rt0 == '0) ? '0 : quo0);
    z1_d = sa.sph1 ? rt1 : ((rt1 == '0) ? '0 : quo1);
  end

  logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
  logic signed [16:0] z0_q, z1_q;
  logic signed [32:0] p_yz_q, p_zy_q, p_zx_q, p_xz_q, p_xy_q, p_yx_q;
  logic signed [16:0] dx_q, dy_q, dz_q;
  logic signed [33:0] c_q [3];
  logic [31:0]        dxx_q, dyy_q, dzz_q;
  logic [31:0]        mag_q [3];
  logic [2:0]         sgn_q;
  logic [33:0]        q_q;
  logic [63:0]        msq_q [3];
  logic [31:0]        mag2_q [3];
  logic [2:0]         sgn2_q;
  logic               qz_q, qb_q;
  logic [63:0]        argy_q, argx_q;
  logic [63:0]        s_q;
  logic [31:0]        mag3_q [3];
  logic [2:0]         sgn3_q;
  logic [33:0]        lim;

  assign lim = 34'({r2_i, 2'b00});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= sa.x0;
      y0_q <= sa.y0;
      x1_q <= sa.x1;
      y1_q <= sa.y1;
      z0_q <= {1'b0, z0_d};
      z1_q <= {1'b0, z1_d};

      p_yz_q <= 33'(y0_q) * 33'(z1_q);
      p_zy_q <= 33'(z0_q) * 33'(y1_q);
      p_zx_q <= 33'(z0_q) * 33'(x1_q);
      p_xz_q <= 33'(x0_q) * 33'(z1_q);
      p_xy_q <= 33'(x0_q) * 33'(y1_q);
      p_yx_q <= 33'(y0_q) * 33'(x1_q);
      dx_q   <= 17'(x1_q) - 17'(x0_q);
      dy_q   <= 17'(y1_q) - 17'(y0_q);
      dz_q   <= z1_q - z0_q;

      c_q[0] <= 34'(p_yz_q) - 34'(p_zy_q);
      c_q[1] <= 34'(p_zx_q) - 34'(p_xz_q);
      c_q[2] <= 34'(p_xy_q) - 34'(p_yx_q);
      dxx_q  <= 32'(34'(dx_q) * 34'(dx_q));
      dyy_q  <= 32'(34'(dy_q) * 34'(dy_q));
      dzz_q  <= 32'(34'(dz_q) * 34'(dz_q));

      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= 32'(c_q[k][33] ? -c_q[k] : c_q[k]);
        sgn_q[k] <= c_q[k][33];
      end
      q_q <= 34'(dxx_q) + 34'(dyy_q) + 34'(dzz_q);

      for (int k = 0; k < 3; k++) begin
        msq_q[k]  <= 64'(mag_q[k]) * 64'(mag_q[k]);
        mag2_q[k] <= mag_q[k];
      end
      sgn2_q <= sgn_q;
      qz_q   <= q_q == '0;
      qb_q   <= q_q >= lim;
      argy_q <= (q_q >= lim) ? '0 : 64'(q_q) << PreBits;
      argx_q <= (q_q >= lim) ? '0 : 64'(lim - q_q) << PreBits;

      s_q    <= msq_q[0] + msq_q[1] + msq_q[2];
      mag3_q <= mag2_q;
      sgn3_q <= sgn2_q;
    end
  end

  // Axis normalisation.
  logic [31:0] len;
  logic [95:0] mg_q [SqrtLat];
  logic [3:0]  sd_q [SidePad];
  logic [15:0] qa0, qa1, qa2;
  logic [47:0] qa_q [AxisPad];
  logic [31:0] mg [3];

  vtr_isqrt u_sqrt_len (.clk_i, .en_i(adv), .rad_i(s_q), .root_o(len));

  always_comb begin
    mg[0] = mg_q[SqrtLat-1][31:0];
    mg[1] = mg_q[SqrtLat-1][63:32];
    mg[2] = mg_q[SqrtLat-1][95:64];
  end

  vtr_div u_div_ax (.clk_i, .en_i(adv), .num_i((48'(mg[0]) << FracBits) + 48'(len >> 1)),
                    .den_i(len), .quo_o(qa0));
  vtr_div u_div_ay (.clk_i, .en_i(adv), .num_i((48'(mg[1]) << FracBits) + 48'(len >> 1)),
                    .den_i(len), .quo_o(qa1));
  vtr_div u_div_az (.clk_i, .en_i(adv), .num_i((48'(mg[2]) << FracBits) + 48'(len >> 1)),
                    .den_i(len), .quo_o(qa2));

  // Angle from the chord length.
  logic [31:0]        ry, rx;
  logic signed [32:0] zang;
  logic [1:0]         fl_q [FlagPad];

  vtr_isqrt u_sqrt_y (.clk_i, .en_i(adv), .rad_i(argy_q), .root_o(ry));
  vtr_isqrt u_sqrt_x (.clk_i, .en_i(adv), .rad_i(argx_q), .root_o(rx));

  vtr_cordic u_cordic (
    .clk_i,
    .en_i(adv),
    .x_i ($signed(49'(rx) << PreBits)),
    .y_i ($signed(49'(ry) << PreBits)),
    .z_o (zang)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mg_q[0] <= {mag3_q[2], mag3_q[1], mag3_q[0]};
      for (int i = 1; i < SqrtLat; i++) begin
        mg_q[i] <= mg_q[i-1];
      end
      sd_q[0] <= {s_q == '0, sgn3_q};
      for (int i = 1; i < SidePad; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
      qa_q[0] <= {qa2, qa1, qa0};
      for (int i = 1; i < AxisPad; i++) begin
        qa_q[i] <= qa_q[i-1];
      end
      fl_q[0] <= {qb_q, qz_q};
      for (int i = 1; i < FlagPad; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  logic [15:0] ax [3];
  logic        deg;
  logic [31:0] zpos;
  logic [33:0] ang_r;
  logic [15:0] ang;

  always_comb begin
    deg = sd_q[SidePad-1][3];
    for (int k = 0; k < 3; k++) begin
      ax[k] = qa_q[AxisPad-1][16*k +: 16];
      if (deg) begin
        ax[k] = '0;
      end else if (sd_q[SidePad-1][k]) begin
        ax[k] = 16'd0 - ax[k];
      end
    end
    zpos  = zang[32] ? '0 : zang[31:0];
    ang_r = ({1'b0, zpos, 1'b0} + (34'd1 << (AngShift - 1))) >> AngShift;
    ang   = (ang_r > 34'(PiFrac)) ? PiFrac : ang_r[15:0];
    if (fl_q[FlagPad-1][0]) begin
      ang = '0;
    end else if (fl_q[FlagPad-1][1]) begin
      ang = PiFrac;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {ang, ax[2], ax[1], ax[0]};
      out_deg_q  <= deg;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_deg_q;

endmodule
